>>> rtl/nibble_pixmap_blitter_macros.svh
// Assertion macros used by the blitter back end.
`ifndef NIBBLE_PIXMAP_BLITTER_MACROS_SVH
`define NIBBLE_PIXMAP_BLITTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define NPB_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("npb assertion failed");

// Next-cycle implication, disabled during reset.
`define NPB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("npb assertion failed");

`endif

>>> rtl/npb_pkg.sv
// Shared types and constants for the nibble pixmap blitter.
`default_nettype none
package npb_pkg;
   localparam int ADDR_W_MAX = 24;
   localparam int DIM_W      = 14;
   localparam int STRIDE_W   = 12;
   localparam int COUNT_W    = 23;
   localparam logic [7:0] LOW_NIB  = 8'h0f;
   localparam logic [7:0] HIGH_NIB = 8'hf0;

   // Configuration register indexes.
   localparam logic [2:0] CSR_SRC_BASE  = 3'd0;
   localparam logic [2:0] CSR_SRC_WIDTH = 3'd1;
   localparam logic [2:0] CSR_DST_BASE  = 3'd2;
   localparam logic [2:0] CSR_DST_WIDTH = 3'd3;

   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_READ   = 2'd1,
      OP_BLIT   = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   typedef struct packed {
      op_type                  op;
      logic [ADDR_W_MAX-1:0]   addr;      // bus address or destination start
      logic [ADDR_W_MAX-1:0]   src_addr;  // source start
      logic [7:0]              wdata;
      logic [7:0]              fill;
      logic                    odd;
      logic [DIM_W-1:0]        width;
      logic [DIM_W-1:0]        height;
      logic [STRIDE_W-1:0]     dstride;
      logic [STRIDE_W-1:0]     sstride;
      logic [COUNT_W-1:0]      count;
   } cmd_type;
endpackage
`default_nettype wire

>>> rtl/npb_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module npb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata <= mem_ff[addr];
   end
endmodule
`default_nettype wire

>>> rtl/npb_front.sv
// Front end: classify incoming transactions and precompute blit geometry.
`default_nettype none
module npb_front #(
   parameter int MAX_DIM = 2048
) (
   input  wire logic [1:0]   opcode,
   input  wire logic [19:0]  mem_addr,
   input  wire logic [7:0]   mem_wdata,
   input  wire logic [10:0]  dest_x,
   input  wire logic [10:0]  dest_y,
   input  wire logic [10:0]  source_x,
   input  wire logic [10:0]  source_y,
   input  wire logic [11:0]  rect_width,
   input  wire logic [11:0]  rect_height,
   input  wire logic [7:0]   fill_bits,
   input  wire logic [19:0]  src_base_addr,
   input  wire logic [11:0]  src_width_px,
   input  wire logic [19:0]  dst_base_addr,
   input  wire logic [11:0]  dst_width_px,
   output logic              has_work,
   output npb_pkg::cmd_type  cmd
);
   localparam int DW = npb_pkg::DIM_W;
   localparam int SW = npb_pkg::STRIDE_W;
   localparam int AWM = npb_pkg::ADDR_W_MAX;

   logic [SW-1:0]   dstride, sstride;
   logic [DW-1:0]   w_sat, h_sat;
   logic [22:0]     drow_off, srow_off;
   logic [2*DW-1:0] area;

   always_comb begin
      dstride  = SW'(({1'b0, dst_width_px} + 13'd1) >> 1);
      sstride  = SW'(({1'b0, src_width_px} + 13'd1) >> 1);
      w_sat    = (DW'(rect_width) > DW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(rect_width);
      h_sat    = (DW'(rect_height) > DW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(rect_height);
      drow_off = dest_y * dstride;
      srow_off = source_y * sstride;
      area     = w_sat * h_sat;

      has_work     = (opcode != npb_pkg::OP_UNUSED);
      cmd.op       = npb_pkg::op_type'(opcode);
      cmd.wdata    = mem_wdata;
      cmd.fill     = fill_bits;
      cmd.odd      = dest_x[0];
      cmd.width    = w_sat;
      cmd.height   = h_sat;
      cmd.dstride  = dstride;
      cmd.sstride  = sstride;
      cmd.count    = area[npb_pkg::COUNT_W-1:0];
      cmd.src_addr = AWM'(src_base_addr) + AWM'(srow_off) + AWM'(source_x[10:1]);
      if (opcode == npb_pkg::OP_BLIT) begin
         cmd.addr = AWM'(dst_base_addr) + AWM'(drow_off) + AWM'(dest_x[10:1]);
      end else begin
         cmd.addr = AWM'(mem_addr);
      end
   end
endmodule
`default_nettype wire

>>> rtl/npb_cmd_fifo.sv
// Two-entry command queue between front and back end.
`default_nettype none
module npb_cmd_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  npb_pkg::cmd_type      push_cmd,
   output logic                  full,
   input  wire logic             pop,
   output npb_pkg::cmd_type      pop_cmd,
   output logic                  empty
);
   npb_pkg::cmd_type slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign pop_cmd = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule
`default_nettype wire

>>> rtl/npb_back.sv
// Back end: bus accesses and the byte-by-byte blit walk over the surface RAM.
`default_nettype none
`include "nibble_pixmap_blitter_macros.svh"
module npb_back #(
   parameter int MEM_BYTES = 1048576
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             cmd_empty,
   input  npb_pkg::cmd_type      cmd,
   output logic                  cmd_pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [7:0]            rsp_read_data,
   output logic [22:0]           rsp_count,
   output logic                  rsp_done
);
   localparam int AW = $clog2(MEM_BYTES);
   localparam int DW = npb_pkg::DIM_W;

   typedef enum logic [2:0] {
      S_IDLE, S_BUS_WR, S_BUS_RD, S_RD_CAP, S_SRC, S_DST, S_WR, S_DONE
   } state_type;

   state_type        state_ff;
   npb_pkg::cmd_type cmd_ff;
   logic [AW-1:0]    d_row_ff, s_row_ff, d_ptr_ff, s_ptr_ff;
   logic [DW-1:0]    j_ff, n_ff, rows_ff;
   logic [7:0]       src_ff, carry_ff, rd_byte_ff;
   logic             rsp_valid_ff;
   logic [7:0]       rsp_data_ff;
   logic [22:0]      rsp_count_ff;
   logic             rsp_done_ff;

   logic          ram_we;
   logic [AW-1:0] ram_addr;
   logic [7:0]    ram_wdata, ram_rdata;
   logic          rsp_free, first, last, wodd, tail;
   logic [7:0]    dst_byte;
   logic [AW-1:0] d_next_row, s_next_row;

   npb_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign cmd_pop    = (state_ff == S_IDLE) && !cmd_empty;
   assign first      = (j_ff == '0);
   assign last       = (j_ff == n_ff - DW'(1));
   assign wodd       = cmd_ff.width[0];
   assign tail       = cmd_ff.odd && last && !wodd;
   assign d_next_row = d_row_ff + AW'(cmd_ff.dstride);
   assign s_next_row = s_row_ff + AW'(cmd_ff.sstride);

   // Merge source nibbles into the destination byte; a bus write takes its byte.
   always_comb begin
      dst_byte = ram_rdata;
      if (state_ff == S_BUS_WR) begin
         ram_wdata = cmd_ff.wdata;
      end else if (!cmd_ff.odd) begin
         if (last && wodd) begin
            ram_wdata = (dst_byte & npb_pkg::LOW_NIB) | (src_ff & npb_pkg::HIGH_NIB)
                        | (cmd_ff.fill & npb_pkg::HIGH_NIB);
         end else begin
            ram_wdata = src_ff | cmd_ff.fill;
         end
      end else if (first) begin
         ram_wdata = (dst_byte & npb_pkg::HIGH_NIB) | (src_ff >> 4)
                     | (cmd_ff.fill & npb_pkg::LOW_NIB);
      end else if (tail) begin
         ram_wdata = (dst_byte & npb_pkg::LOW_NIB) | (carry_ff << 4)
                     | (cmd_ff.fill & npb_pkg::HIGH_NIB);
      end else begin
         ram_wdata = (carry_ff << 4) | (src_ff >> 4) | cmd_ff.fill;
      end
   end

   always_comb begin
      ram_we   = 1'b0;
      ram_addr = d_ptr_ff;
      case (state_ff)
         S_BUS_WR: begin
            ram_we    = 1'b1;
            ram_addr  = cmd_ff.addr[AW-1:0];
         end
         S_BUS_RD: ram_addr = cmd_ff.addr[AW-1:0];
         S_SRC:    ram_addr = s_ptr_ff;
         S_WR:     ram_we   = 1'b1;
         default:  ram_addr = d_ptr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         carry_ff     <= 8'd0;
      end else begin
         if (rsp_valid_ff && rsp_ready && state_ff != S_DONE) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (!cmd_empty) begin
                  cmd_ff   <= cmd;
                  d_row_ff <= cmd.addr[AW-1:0];
                  d_ptr_ff <= cmd.addr[AW-1:0];
                  s_row_ff <= cmd.src_addr[AW-1:0];
                  s_ptr_ff <= cmd.src_addr[AW-1:0];
                  j_ff     <= '0;
                  rows_ff  <= cmd.height;
                  n_ff     <= cmd.odd ? DW'((cmd.width >> 1) + DW'(1))
                                      : DW'(({1'b0, cmd.width} + 15'd1) >> 1);
                  case (cmd.op)
                     npb_pkg::OP_WRITE: state_ff <= S_BUS_WR;
                     npb_pkg::OP_READ:  state_ff <= S_BUS_RD;
                     default: begin
                        if (cmd.width == '0 || cmd.height == '0) state_ff <= S_DONE;
                        else state_ff <= S_SRC;
                     end
                  endcase
               end
            end
            S_BUS_WR: state_ff <= S_IDLE;
            S_BUS_RD: state_ff <= S_RD_CAP;
            S_RD_CAP: begin
               rd_byte_ff <= ram_rdata;
               state_ff   <= S_DONE;
            end
            S_SRC: state_ff <= S_DST;
            S_DST: begin
               src_ff   <= ram_rdata;
               state_ff <= S_WR;
            end
            S_WR: begin
               if (cmd_ff.odd && !tail) carry_ff <= src_ff;
               if (last) begin
                  if (rows_ff == DW'(1)) begin
                     state_ff <= S_DONE;
                  end else begin
                     rows_ff  <= rows_ff - DW'(1);
                     d_row_ff <= d_next_row;
                     s_row_ff <= s_next_row;
                     d_ptr_ff <= d_next_row;
                     s_ptr_ff <= s_next_row;
                     j_ff     <= '0;
                     state_ff <= S_SRC;
                  end
               end else begin
                  j_ff     <= j_ff + DW'(1);
                  d_ptr_ff <= d_ptr_ff + AW'(1);
                  s_ptr_ff <= s_ptr_ff + AW'(1);
                  state_ff <= S_SRC;
               end
            end
            S_DONE: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  if (cmd_ff.op == npb_pkg::OP_READ) begin
                     rsp_data_ff  <= rd_byte_ff;
                     rsp_count_ff <= '0;
                     rsp_done_ff  <= 1'b0;
                  end else begin
                     rsp_data_ff  <= 8'd0;
                     rsp_count_ff <= cmd_ff.count;
                     rsp_done_ff  <= 1'b1;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_count     = rsp_count_ff;
   assign rsp_done      = rsp_done_ff;

   `NPB_ASSERT_NOW(a_we_state, clock, reset, ram_we, (state_ff == S_WR || state_ff == S_BUS_WR))
   `NPB_ASSERT_NOW(a_pop_idle, clock, reset, cmd_pop, (state_ff == S_IDLE && !cmd_empty))
   `NPB_ASSERT_NEXT(a_done_rsp, clock, reset, (state_ff == S_DONE && rsp_free), rsp_valid_ff)
endmodule
`default_nettype wire

>>> rtl/nibble_pixmap_blitter.sv
// Top level of the 4-bit-per-pixel blit engine.
//
// Channels: req_* carries one command transaction (write byte, read byte,
// blit); rsp_* returns one transaction for a read or a finished blit; a
// write returns nothing and unused opcode 3 is dropped. csr_* writes the
// source/destination base and width registers, index 0..3, always ready.
// A front end classifies each command and precomputes row start addresses
// and the pixel count; a two-entry queue decouples it from the back end,
// which owns the single-port surface RAM.
// With the back end idle, a bus write holds it in S_BUS_WR; a read passes
// S_BUS_RD, S_RD_CAP and S_DONE before rsp_tvalid rises. A blit walks each
// destination byte through S_SRC, S_DST and S_WR (source read, destination
// read, write on the one RAM port), rows of width/2 bytes plus one for an odd
// column or odd width; S_DONE then raises rsp_tvalid. An empty blit skips the walk.
// Reset clears control state and registers; surface memory is not cleared.
// When rsp_tready is low the result holds in the output register, the back
// end waits on the next result, and the queue fills, then req_tready drops.
`default_nettype none
module nibble_pixmap_blitter #(
   parameter int MEM_BYTES = 1048576,
   parameter int MAX_DIM   = 2048
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // mem_addr, mem_wdata, dest_x, dest_y, source_x, source_y,
   // rect_width, rect_height, fill_bits
   input  wire logic [103:0] req_tdata,
   input  wire logic [1:0]   req_tuser,   // opcode
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [31:0]       rsp_tdata,   // read_data, pixel_count, zero pad
   output logic              rsp_tuser,   // is_blit_done
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [2:0]   csr_index,
   input  wire logic [19:0]  csr_wdata
);
   logic [19:0] src_base_ff, dst_base_ff;
   logic [11:0] src_width_ff, dst_width_ff;

   npb_pkg::cmd_type front_cmd, queue_cmd;
   logic has_work, q_full, q_empty, q_pop, q_push;
   logic [7:0]  rsp_read_data;
   logic [22:0] rsp_count;

   assign csr_ready = 1'b1;

   // Take configuration writes; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         src_base_ff  <= 20'd0;
         src_width_ff <= 12'd2048;
         dst_base_ff  <= 20'd0;
         dst_width_ff <= 12'd2048;
      end else if (csr_valid) begin
         case (csr_index)
            npb_pkg::CSR_SRC_BASE:  src_base_ff  <= csr_wdata;
            npb_pkg::CSR_SRC_WIDTH: src_width_ff <= csr_wdata[11:0];
            npb_pkg::CSR_DST_BASE:  dst_base_ff  <= csr_wdata;
            npb_pkg::CSR_DST_WIDTH: dst_width_ff <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   npb_front #(.MAX_DIM(MAX_DIM)) u_front (
      .opcode        (req_tuser),
      .mem_addr      (req_tdata[19:0]),
      .mem_wdata     (req_tdata[27:20]),
      .dest_x        (req_tdata[38:28]),
      .dest_y        (req_tdata[49:39]),
      .source_x      (req_tdata[60:50]),
      .source_y      (req_tdata[71:61]),
      .rect_width    (req_tdata[83:72]),
      .rect_height   (req_tdata[95:84]),
      .fill_bits     (req_tdata[103:96]),
      .src_base_addr (src_base_ff),
      .src_width_px  (src_width_ff),
      .dst_base_addr (dst_base_ff),
      .dst_width_px  (dst_width_ff),
      .has_work      (has_work),
      .cmd           (front_cmd)
   );

   // Accept whenever the queue has room; drop commands with no work.
   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full && has_work;

   npb_cmd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (front_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .pop_cmd  (queue_cmd),
      .empty    (q_empty)
   );

   npb_back #(.MEM_BYTES(MEM_BYTES)) u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_empty     (q_empty),
      .cmd           (queue_cmd),
      .cmd_pop       (q_pop),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_read_data (rsp_read_data),
      .rsp_count     (rsp_count),
      .rsp_done      (rsp_tuser)
   );

   assign rsp_tdata = {1'b0, rsp_count, rsp_read_data};
endmodule
`default_nettype wire

>>> dv/tb_nibble_pixmap_blitter.sv
// Self-checking testbench for the 4-bit-per-pixel blit engine.
`default_nettype none

module tb_nibble_pixmap_blitter;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] REG_UNLISTED  = 3'd5;
   localparam int unsigned ADDR_MASK = 32'hfffff;
   localparam int unsigned DIM_LIMIT = 2048;

   typedef struct {
      logic [1:0]  opcode;
      logic [19:0] addr;
      logic [7:0]  wdata;
      logic [10:0] dx, dy, sx, sy;
      logic [11:0] w, h;
      logic [7:0]  fill;
   } command_type;

   typedef struct {
      logic [7:0]  read_data;
      logic [22:0] pixel_count;
      logic        is_blit_done;
   } reply_type;

   // Tracks surface memory, registers and the replies still owed by the block.
   class blit_scoreboard;
      logic [7:0]  surface [int unsigned];
      int unsigned written_q[$];
      reply_type   pending_replies[$];
      logic [7:0]  carry;
      logic [19:0] src_base, dst_base;
      logic [11:0] src_width, dst_width;
      int          errors;

      function void reset_state();
         surface.delete();
         written_q.delete();
         pending_replies.delete();
         carry = '0;
         src_base = '0;
         dst_base = '0;
         src_width = 12'd2048;
         dst_width = 12'd2048;
         errors = 0;
      endfunction

      function void write_reg(logic [2:0] index, logic [19:0] value);
         case (index)
            npb_pkg::CSR_SRC_BASE:  src_base = value;
            npb_pkg::CSR_SRC_WIDTH: src_width = value[11:0];
            npb_pkg::CSR_DST_BASE:  dst_base = value;
            npb_pkg::CSR_DST_WIDTH: dst_width = value[11:0];
            default: ;
         endcase
      endfunction

      function logic [7:0] peek(longint unsigned a);
         int unsigned k;
         k = int'(a & ADDR_MASK);
         if (!surface.exists(k)) return 8'h00;
         return surface[k];
      endfunction

      function bit is_written(longint unsigned a);
         return surface.exists(int'(a & ADDR_MASK));
      endfunction

      function void poke(longint unsigned a, logic [7:0] v);
         int unsigned k;
         k = int'(a & ADDR_MASK);
         if (!surface.exists(k)) written_q.push_back(k);
         surface[k] = v;
      endfunction

      // One destination row; the shifted walk reads each source byte once.
      function void copy_row(longint unsigned d, longint unsigned s, int unsigned width,
                             bit odd, logic [7:0] fill);
         int unsigned n;
         logic [7:0] sb;
         if (!odd) begin
            n = width / 2;
            for (int unsigned j = 0; j < n; j++) poke(d + j, peek(s + j) | fill);
            if (width[0]) begin
               sb = peek(s + n);
               poke(d + n, (peek(d + n) & npb_pkg::LOW_NIB) | (sb & npb_pkg::HIGH_NIB)
                           | (fill & npb_pkg::HIGH_NIB));
            end
         end else begin
            n = (width + 1) / 2;
            sb = peek(s);
            poke(d, (peek(d) & npb_pkg::HIGH_NIB) | (sb >> 4) | (fill & npb_pkg::LOW_NIB));
            carry = sb;
            for (int unsigned j = 1; j < n; j++) begin
               sb = peek(s + j);
               poke(d + j, {carry[3:0], 4'h0} | (sb >> 4) | fill);
               carry = sb;
            end
            if (!width[0])
               poke(d + n, (peek(d + n) & npb_pkg::LOW_NIB) | {carry[3:0], 4'h0}
                           | (fill & npb_pkg::HIGH_NIB));
         end
      endfunction

      // Apply one accepted command and queue the reply it owes.
      function void note_command(command_type c);
         reply_type r;
         int unsigned w, h;
         longint unsigned ds, ss, d, s;
         case (c.opcode)
            npb_pkg::OP_WRITE: poke(c.addr, c.wdata);
            npb_pkg::OP_READ: begin
               r.read_data = peek(c.addr);
               r.pixel_count = '0;
               r.is_blit_done = 1'b0;
               pending_replies.push_back(r);
            end
            npb_pkg::OP_BLIT: begin
               w = (c.w > DIM_LIMIT) ? DIM_LIMIT : c.w;
               h = (c.h > DIM_LIMIT) ? DIM_LIMIT : c.h;
               ds = (longint'(dst_width) + 1) / 2;
               ss = (longint'(src_width) + 1) / 2;
               if (w != 0) begin
                  for (int unsigned i = 0; i < h; i++) begin
                     d = longint'(dst_base) + (longint'(c.dy) + i) * ds + c.dx / 2;
                     s = longint'(src_base) + (longint'(c.sy) + i) * ss + c.sx / 2;
                     copy_row(d, s, w, c.dx[0], c.fill);
                  end
               end
               r.read_data = '0;
               r.pixel_count = 23'(w * h);
               r.is_blit_done = 1'b1;
               pending_replies.push_back(r);
            end
            default: ;
         endcase
      endfunction

      function void check_response(logic [7:0] rd, logic [22:0] cnt, logic done);
         reply_type e;
         if (pending_replies.size() == 0) begin
            $error("unexpected response: read_data=%0h pixel_count=%0d is_blit_done=%0b",
                   rd, cnt, done);
            errors++;
            return;
         end
         e = pending_replies.pop_front();
         if (rd !== e.read_data) begin
            $error("read_data: expected %0h, actual %0h", e.read_data, rd);
            errors++;
         end
         if (cnt !== e.pixel_count) begin
            $error("pixel_count: expected %0d, actual %0d", e.pixel_count, cnt);
            errors++;
         end
         if (done !== e.is_blit_done) begin
            $error("is_blit_done: expected %0b, actual %0b", e.is_blit_done, done);
            errors++;
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [103:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [31:0]  rsp_tdata;
   logic         rsp_tuser;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [2:0]   csr_index = '0;
   logic [19:0]  csr_wdata = '0;

   blit_scoreboard sb = new();
   int unsigned    send_idle_pct = 23;
   int unsigned    rsp_idle_pct = 83;
   int unsigned    items_sent = 0;

   always #5 clock = ~clock;

   nibble_pixmap_blitter u_top (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata
   );

   // Drive one command transaction; hold it until the block takes it.
   task automatic send_command(command_type c);
      if ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat ($urandom_range(4)) @(negedge clock);
      end else begin
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = c.opcode;
      req_tdata = {c.fill, c.h, c.w, c.sy, c.sx, c.dy, c.dx, c.wdata, c.addr};
      do @(posedge clock); while (!req_tready);
      sb.note_command(c);
      items_sent++;
   endtask

   task automatic write_byte(logic [19:0] a, logic [7:0] v);
      command_type c;
      c = '{default: '0};
      c.opcode = npb_pkg::OP_WRITE;
      c.addr = a;
      c.wdata = v;
      send_command(c);
   endtask

   task automatic read_byte(logic [19:0] a);
      command_type c;
      c = '{default: '0};
      c.opcode = npb_pkg::OP_READ;
      c.addr = a;
      send_command(c);
   endtask

   // Load every byte a blit may read that holds nothing yet, then run it.
   task automatic run_blit(command_type c);
      int unsigned w, h;
      longint unsigned ds, ss, d, s;
      w = (c.w > DIM_LIMIT) ? DIM_LIMIT : c.w;
      h = (c.h > DIM_LIMIT) ? DIM_LIMIT : c.h;
      ds = (longint'(sb.dst_width) + 1) / 2;
      ss = (longint'(sb.src_width) + 1) / 2;
      if (w != 0) begin
         for (int unsigned i = 0; i < h; i++) begin
            d = longint'(sb.dst_base) + (longint'(c.dy) + i) * ds + c.dx / 2;
            s = longint'(sb.src_base) + (longint'(c.sy) + i) * ss + c.sx / 2;
            for (int unsigned j = 0; j <= w / 2; j++) begin
               if (!sb.is_written(s + j))
                  write_byte(20'((s + j) & ADDR_MASK), 8'($urandom));
               if (!sb.is_written(d + j))
                  write_byte(20'((d + j) & ADDR_MASK), 8'($urandom));
            end
         end
      end
      c.opcode = npb_pkg::OP_BLIT;
      send_command(c);
   endtask

   task automatic blit(logic [10:0] dx, logic [10:0] dy, logic [10:0] sx, logic [10:0] sy,
                       logic [11:0] w, logic [11:0] h, logic [7:0] fill);
      command_type c;
      c = '{default: '0};
      c.dx = dx; c.dy = dy; c.sx = sx; c.sy = sy;
      c.w = w; c.h = h; c.fill = fill;
      run_blit(c);
   endtask

   // Stop sending until every owed reply has come back.
   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (sb.pending_replies.size() != 0) @(negedge clock);
   endtask

   // Registers change only with the block idle; a trailing write needs no reply.
   task automatic write_csr(logic [2:0] index, logic [19:0] value);
      drain();
      repeat (20) @(negedge clock);
      csr_valid = 1'b1;
      csr_index = index;
      csr_wdata = value;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(index, value);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic random_command();
      command_type c;
      int unsigned pick;
      c = '{default: '0};
      c.addr = 20'($urandom);
      c.wdata = 8'($urandom);
      c.fill = ($urandom_range(2) == 0) ? 8'($urandom) : 8'h00;
      pick = $urandom_range(99);
      if (pick < 25) begin
         write_byte(($urandom_range(3) == 0) ? c.addr : 20'($urandom_range(255)), c.wdata);
      end else if (pick < 50) begin
         if (sb.written_q.size() != 0)
            read_byte(20'(sb.written_q[$urandom_range(sb.written_q.size() - 1)]));
      end else if (pick < 95) begin
         if ($urandom_range(6) != 0) begin
            c.dx = 11'($urandom_range(9)); c.dy = 11'($urandom_range(6));
            c.sx = 11'($urandom_range(9)); c.sy = 11'($urandom_range(6));
            c.w = 12'($urandom_range(13)); c.h = 12'($urandom_range(4));
         end else begin
            c.dx = 11'($urandom); c.dy = 11'($urandom);
            c.sx = 11'($urandom); c.sy = 11'($urandom);
            c.w = 12'($urandom_range(6)); c.h = 12'($urandom_range(2));
            // Oversize dimension paired with an empty one stays cheap.
            if ($urandom_range(3) == 0) begin
               if ($urandom_range(1)) begin c.w = 12'($urandom_range(4095, 2049)); c.h = '0; end
               else begin c.h = 12'($urandom_range(4095, 2049)); c.w = '0; end
            end
         end
         run_blit(c);
      end else begin
         c.opcode = npb_pkg::OP_UNUSED;
         send_command(c);
      end
   endtask

   task automatic random_phase(int unsigned count);
      int unsigned stop_at;
      stop_at = items_sent + count;
      while (items_sent < stop_at) random_command();
   endtask

   // Receive side: randomize ready at the falling edge, check at the rising edge.
   initial begin
      forever begin
         @(negedge clock);
         rsp_tready = ($urandom_range(99) >= rsp_idle_pct);
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            sb.check_response(rsp_tdata[7:0], rsp_tdata[30:8], rsp_tuser);
      end
   end

   initial begin
      #50ms;
      $display("FAIL nibble_pixmap_blitter");
      $finish;
   end

   initial begin
      int unsigned waited;
      sb.reset_state();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: address extremes, unused opcode, edge cases of the blit.
      write_byte(20'h00000, 8'hff);
      write_byte(20'hfffff, 8'h00);
      read_byte(20'h00000);
      read_byte(20'hfffff);
      write_byte(20'hfffff, 8'ha5);
      read_byte(20'hfffff);
      begin
         command_type c;
         c = '{default: '1};
         c.opcode = npb_pkg::OP_UNUSED;
         send_command(c);
      end
      write_csr(npb_pkg::CSR_SRC_WIDTH, 20'd16);
      write_csr(npb_pkg::CSR_DST_WIDTH, 20'd17);
      write_csr(npb_pkg::CSR_SRC_BASE, 20'h00100);
      write_csr(npb_pkg::CSR_DST_BASE, 20'hfffe0);
      write_csr(REG_UNLISTED, 20'hfffff);
      blit(0, 0, 0, 0, 12'd0, 12'd4095, 8'h00);     // empty width, oversize height
      blit(0, 0, 0, 0, 12'd4095, 12'd0, 8'h00);     // empty height, oversize width
      blit(2, 1, 4, 0, 12'd6, 12'd3, 8'h00);        // aligned even width
      blit(4, 2, 2, 1, 12'd5, 12'd2, 8'h0f);        // aligned odd width, partial edge
      blit(3, 0, 0, 0, 12'd6, 12'd2, 8'hf0);        // odd column, even width
      blit(1, 3, 7, 2, 12'd7, 12'd3, 8'hff);        // odd column, odd width, ignored sx bit
      blit(0, 0, 0, 0, 12'd1, 12'd1, 8'h00);
      blit(1, 0, 0, 0, 12'd1, 12'd1, 8'h00);
      write_csr(npb_pkg::CSR_SRC_BASE, 20'hfffe0);  // overlap with destination
      blit(1, 0, 0, 0, 12'd9, 12'd2, 8'h00);
      blit(2047, 2047, 2047, 2047, 12'd3, 12'd1, 8'h00);
      write_csr(npb_pkg::CSR_SRC_WIDTH, 20'd2048);
      write_csr(npb_pkg::CSR_DST_WIDTH, 20'd2048);
      write_csr(npb_pkg::CSR_DST_BASE, 20'hfffe0);
      blit(1, 0, 0, 0, 12'd4095, 12'd1, 8'h00);     // full width, saturated, overlapping
      read_byte(20'hfffe0);
      read_byte(20'h003e0);

      // Random: three idling mixes, registers changed in between.
      write_csr(npb_pkg::CSR_SRC_BASE, 20'($urandom));
      write_csr(npb_pkg::CSR_SRC_WIDTH, 20'($urandom_range(40, 1)));
      write_csr(npb_pkg::CSR_DST_BASE, 20'($urandom));
      write_csr(npb_pkg::CSR_DST_WIDTH, 20'($urandom_range(40, 1)));
      random_phase(120);
      drain();                                       // pause until all replies arrive
      random_phase(80);

      send_idle_pct = 83;
      rsp_idle_pct = 23;
      write_csr(npb_pkg::CSR_SRC_BASE, 20'hfffff);
      write_csr(npb_pkg::CSR_SRC_WIDTH, 20'd1);
      write_csr(npb_pkg::CSR_DST_BASE, 20'h00000);
      write_csr(npb_pkg::CSR_DST_WIDTH, 20'd2048);
      random_phase(100);
      write_csr(npb_pkg::CSR_SRC_WIDTH, 20'd2048);
      write_csr(npb_pkg::CSR_DST_WIDTH, 20'd1);
      random_phase(100);

      send_idle_pct = 0;
      rsp_idle_pct = 0;
      write_csr(npb_pkg::CSR_SRC_BASE, 20'($urandom));
      write_csr(npb_pkg::CSR_SRC_WIDTH, 20'($urandom_range(2048, 1)));
      write_csr(npb_pkg::CSR_DST_BASE, 20'($urandom));
      write_csr(npb_pkg::CSR_DST_WIDTH, 20'($urandom_range(64, 1)));
      random_phase(130);
      write_csr(npb_pkg::CSR_SRC_BASE, 20'h00000);
      write_csr(npb_pkg::CSR_SRC_WIDTH, 20'($urandom_range(24, 1)));
      write_csr(npb_pkg::CSR_DST_BASE, 20'h00000);
      write_csr(npb_pkg::CSR_DST_WIDTH, 20'($urandom_range(24, 1)));
      random_phase(120);

      // Wind down: release the bus, wait for the last replies, then settle.
      @(negedge clock);
      req_tvalid = 1'b0;
      waited = 0;
      while (sb.pending_replies.size() != 0 && waited < 200000) begin
         @(negedge clock);
         waited++;
      end
      repeat (100) @(negedge clock);
      if (sb.errors == 0 && sb.pending_replies.size() == 0) begin
         $display("PASS nibble_pixmap_blitter");
      end else begin
         if (sb.pending_replies.size() != 0)
            $error("%0d expected responses never arrived", sb.pending_replies.size());
         $display("FAIL nibble_pixmap_blitter");
      end
      $finish;
   end
endmodule

`default_nettype wire
